// ===== rtl/mwxss_pkg.sv =====
`timescale 1ns / 1ps

package mwxss_pkg;

    // Fixed field widths of the request and result channels.
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 5;
    localparam int MASK_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int PRESS_W  = 5;
    localparam int TOTAL_W  = 24;

    // Saturation ceiling of the running total.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_SOLVE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

endpackage

// ===== rtl/min_weight_xor_subset_search.sv =====
`timescale 1ns / 1ps

// Minimum-weight XOR subset search. A load request stores a button's toggle mask,
// a clear request zeroes the running total, and neither gives a result. A solve
// request walks every subset of buttons 0..n-1 (n is button_count, capped at
// BUTTONS) in Gray-code order, so each cycle flips exactly one button into or out
// of a single shared XOR accumulator and compares it to the target. A solve
// starts, walks the 2^n - 1 nonempty subsets, and posts the result once the output
// register is free; the result then waits there until taken. The input is not
// ready during a solve. A solve that uses a button slot never loaded since reset
// gives an undefined answer. Without a match, found is 0, min_presses is 0 and
// the total is left unchanged; a zero target matches the empty subset.
module min_weight_xor_subset_search #(
    parameter int BUTTONS = 20,
    parameter int LIGHTS  = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mwxss_pkg::OP_W-1:0]      s_op,
    input  logic [mwxss_pkg::INDEX_W-1:0]   s_button_index,
    input  logic [mwxss_pkg::MASK_W-1:0]    s_toggle_mask,
    input  logic [mwxss_pkg::MASK_W-1:0]    s_target_pattern,
    input  logic [mwxss_pkg::COUNT_W-1:0]   s_button_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mwxss_pkg::PRESS_W-1:0]   m_min_presses,
    output logic                            m_found,
    output logic [mwxss_pkg::TOTAL_W-1:0]   m_running_total
);

    localparam int MW = mwxss_pkg::MASK_W;
    localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int WW = $clog2(BUTTONS + 1);
    localparam int PW = mwxss_pkg::PRESS_W;
    localparam int TW = mwxss_pkg::TOTAL_W;
    localparam int CW = mwxss_pkg::COUNT_W;
    localparam logic [MW-1:0] LIGHT_MASK =
        (LIGHTS >= MW) ? {MW{1'b1}} : MW'((64'd1 << LIGHTS) - 64'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // Index of the lowest set bit of the step counter: the button that flips.
    function automatic logic [IW-1:0] lowest_set(input logic [BUTTONS-1:0] v);
        logic [IW-1:0] j;
        j = '0;
        for (int b = BUTTONS - 1; b >= 0; b--) begin
            if (v[b]) begin
                j = IW'(b);
            end
        end
        return j;
    endfunction

    logic [MW-1:0]      mask_mem [BUTTONS];

    state_t             state_reg, state_next;
    logic [BUTTONS-1:0] k_reg, k_next;
    logic [BUTTONS-1:0] last_k_reg, last_k_next;
    logic [BUTTONS-1:0] sel_reg, sel_next;
    logic [MW-1:0]      acc_reg, acc_next;
    logic [MW-1:0]      target_reg, target_next;
    logic [WW-1:0]      weight_reg, weight_next;
    logic [WW-1:0]      best_reg, best_next;
    logic               found_reg, found_next;
    logic [TW-1:0]      total_reg, total_next;
    logic               m_valid_reg, m_valid_next;
    logic [PW-1:0]      m_min_presses_reg, m_min_presses_next;
    logic               m_found_reg, m_found_next;
    logic [TW-1:0]      m_total_reg, m_total_next;

    logic               s_fire;
    mwxss_pkg::op_t     op;
    logic [CW-1:0]      count_sat;
    logic [IW-1:0]      flip_idx;
    logic [MW-1:0]      step_acc;
    logic [WW-1:0]      step_weight;
    logic [TW:0]        sum_wide;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign op      = mwxss_pkg::op_t'(s_op);

    assign m_valid         = m_valid_reg;
    assign m_min_presses   = m_min_presses_reg;
    assign m_found         = m_found_reg;
    assign m_running_total = m_total_reg;

    // Button count capped at the number of slots.
    assign count_sat = (s_button_count > CW'(BUTTONS)) ? CW'(BUTTONS) : s_button_count;

    // One Gray-code step: flip one button into the accumulator and weight.
    assign flip_idx    = lowest_set(k_reg);
    assign step_acc    = acc_reg ^ mask_mem[flip_idx];
    assign step_weight = sel_reg[flip_idx] ? (weight_reg - WW'(1)) : (weight_reg + WW'(1));

    // Saturating update of the total with the best weight.
    assign sum_wide = {1'b0, total_reg} + (TW + 1)'(best_reg);

    // Mask storage, written by load requests that name a valid slot.
    always_ff @(posedge aclk) begin
        if (s_fire && op == mwxss_pkg::OP_LOAD && s_button_index < mwxss_pkg::INDEX_W'(BUTTONS)) begin
            mask_mem[s_button_index[IW-1:0]] <= s_toggle_mask & LIGHT_MASK;
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next         = state_reg;
        k_next             = k_reg;
        last_k_next        = last_k_reg;
        sel_next           = sel_reg;
        acc_next           = acc_reg;
        target_next        = target_reg;
        weight_next        = weight_reg;
        best_next          = best_reg;
        found_next         = found_reg;
        total_next         = total_reg;
        m_valid_next       = m_valid_reg;
        m_min_presses_next = m_min_presses_reg;
        m_found_next       = m_found_reg;
        m_total_next       = m_total_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (op)
                        mwxss_pkg::OP_SOLVE: begin
                            k_next      = BUTTONS'(1);
                            last_k_next = {BUTTONS{1'b1}} >> (BUTTONS - int'(count_sat));
                            sel_next    = '0;
                            acc_next    = '0;
                            weight_next = '0;
                            best_next   = '0;
                            target_next = s_target_pattern & LIGHT_MASK;
                            found_next  = ((s_target_pattern & LIGHT_MASK) == '0);
                            state_next  = (count_sat == '0) ? ST_FINISH : ST_RUN;
                        end
                        mwxss_pkg::OP_CLEAR: begin
                            total_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                acc_next           = step_acc;
                sel_next           = sel_reg;
                sel_next[flip_idx] = ~sel_reg[flip_idx];
                weight_next        = step_weight;
                k_next             = k_reg + BUTTONS'(1);
                if (step_acc == target_reg && (!found_reg || step_weight < best_reg)) begin
                    found_next = 1'b1;
                    best_next  = step_weight;
                end
                if (k_reg == last_k_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Post the result once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_found_next       = found_reg;
                    m_min_presses_next = found_reg ? PW'(best_reg) : '0;
                    if (found_reg) begin
                        total_next   = (sum_wide > {1'b0, mwxss_pkg::TOTAL_MAX}) ?
                                       mwxss_pkg::TOTAL_MAX : sum_wide[TW-1:0];
                        m_total_next = total_next;
                    end else begin
                        m_total_next = total_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, datapath and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg             <= k_next;
        last_k_reg        <= last_k_next;
        sel_reg           <= sel_next;
        acc_reg           <= acc_next;
        target_reg        <= target_next;
        weight_reg        <= weight_next;
        best_reg          <= best_next;
        found_reg         <= found_next;
        m_min_presses_reg <= m_min_presses_next;
        m_found_reg       <= m_found_next;
        m_total_reg       <= m_total_next;
    end

    // The tracked weight always equals the number of selected buttons.
    a_weight_tracks_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> weight_reg == WW'($countones(sel_reg)))
        else $error("subset weight out of step with selection");

    // The walk counter never reaches zero while stepping.
    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> k_reg != '0)
        else $error("Gray-code step counter wrapped");

    // A result without a match reports zero presses.
    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_min_presses == '0)
        else $error("no-match result carries nonzero presses");

    // A new result is only posted after the previous one was taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg)
        else $error("pending result dropped");

endmodule

// ===== test/min_weight_xor_subset_search_test.sv =====
`timescale 1ns / 1ps

// One expected solve answer.
typedef struct packed {
    bit [4:0]  presses;
    bit        found;
    bit [23:0] total;
} solve_outcome_t;

// Keeps a shadow of the button masks and the running total, works out the
// answer of every accepted solve, and checks the answers that come back.
class min_press_book #(int SLOTS = 20);
    bit [15:0]      slot_mask [SLOTS];
    bit [23:0]      total;
    solve_outcome_t expected_solves [$];
    int             mismatches;
    int             answers_seen;

    // Apply one accepted request to the shadow state.
    function void note_request(mwxss_pkg::op_t op, bit [4:0] idx, bit [15:0] mask,
                               bit [15:0] target, bit [4:0] count);
        if (op == mwxss_pkg::OP_LOAD) begin
            if (idx < SLOTS)
                slot_mask[idx] = mask;
        end else if (op == mwxss_pkg::OP_CLEAR) begin
            total = '0;
        end else if (op == mwxss_pkg::OP_SOLVE) begin
            expected_solves.insert(expected_solves.size(), search_min_presses(target, count));
        end
    endfunction

    // Walk all subsets of the first slots in Gray-code order, one flip per step,
    // and keep the lightest subset whose XOR hits the target.
    function solve_outcome_t search_min_presses(bit [15:0] target, bit [4:0] count);
        solve_outcome_t answer;
        bit [15:0]      acc;
        bit [SLOTS-1:0] chosen;
        bit [24:0]      sum;
        bit             hit;
        int             span;
        int             weight;
        int             best;
        int             b;
        span   = (count > SLOTS) ? SLOTS : count;
        acc    = '0;
        chosen = '0;
        weight = 0;
        best   = 0;
        hit    = (target == '0);
        for (int step = 1; step < (1 << span); step++) begin
            b = 0;
            while (!step[b])
                b++;
            acc ^= slot_mask[b];
            chosen[b] = !chosen[b];
            weight += chosen[b] ? 1 : -1;
            if (acc == target && (!hit || weight < best)) begin
                hit  = 1'b1;
                best = weight;
            end
        end
        // Only a match moves the total, and it saturates at the top.
        if (hit) begin
            sum   = {1'b0, total} + 25'(best);
            total = (sum > mwxss_pkg::TOTAL_MAX) ? mwxss_pkg::TOTAL_MAX : sum[23:0];
        end
        answer.presses = hit ? best[4:0] : '0;
        answer.found   = hit;
        answer.total   = total;
        return answer;
    endfunction

    function int pending();
        return expected_solves.size();
    endfunction

    // Compare one delivered answer against the oldest one still owed.
    function void check_result(logic [4:0] presses, logic found, logic [23:0] total_out);
        solve_outcome_t want;
        answers_seen++;
        if (expected_solves.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("answer %0d with no solve owed: presses=%0d found=%0d total=%0d",
                         answers_seen, presses, found, total_out);
            return;
        end
        want = expected_solves.pop_front();
        if (presses !== want.presses || found !== want.found || total_out !== want.total) begin
            mismatches++;
            if (mismatches <= 10)
                $display("answer %0d: expected presses=%0d found=%0d total=%0d, ",
                         answers_seen, want.presses, want.found, want.total,
                         "got presses=%0d found=%0d total=%0d",
                         presses, found, total_out);
        end
    endfunction

    // Anything still owed at the end is a failure.
    function void close_out();
        if (expected_solves.size() != 0) begin
            mismatches += expected_solves.size();
            $display("%0d solve answers never arrived", expected_solves.size());
        end
    endfunction
endclass

module min_weight_xor_subset_search_test;

    localparam int BUTTONS = 20;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [mwxss_pkg::OP_W-1:0]          s_op;
    logic [mwxss_pkg::INDEX_W-1:0]       s_button_index;
    logic [mwxss_pkg::MASK_W-1:0]        s_toggle_mask;
    logic [mwxss_pkg::MASK_W-1:0]        s_target_pattern;
    logic [mwxss_pkg::COUNT_W-1:0]       s_button_count;
    logic                                m_valid;
    logic                                m_ready;
    logic [mwxss_pkg::PRESS_W-1:0]       m_min_presses;
    logic                                m_found;
    logic [mwxss_pkg::TOTAL_W-1:0]       m_running_total;

    min_press_book #(BUTTONS) book;
    bit [BUTTONS-1:0]         loaded;
    bit                       steady;

    min_weight_xor_subset_search #(
        .BUTTONS(BUTTONS),
        .LIGHTS (16)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_button_index  (s_button_index),
        .s_toggle_mask   (s_toggle_mask),
        .s_target_pattern(s_target_pattern),
        .s_button_count  (s_button_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_min_presses   (m_min_presses),
        .m_found         (m_found),
        .m_running_total (m_running_total)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle cycles before the next request or answer; none during steady stretches.
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    // Number of slots loaded without a hole, counting up from slot 0.
    function automatic int loaded_prefix();
        int k;
        k = 0;
        while (k < BUTTONS && loaded[k])
            k++;
        return k;
    endfunction

    // Present one request and hold it until it is taken. Called and left at a
    // falling edge; valid stays high so back-to-back requests need no bubble.
    task automatic put_request(mwxss_pkg::op_t op, bit [4:0] idx, bit [15:0] mask,
                               bit [15:0] target, bit [4:0] count);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_button_index   <= idx;
        s_toggle_mask    <= mask;
        s_target_pattern <= target;
        s_button_count   <= count;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        book.note_request(op, idx, mask, target, count);
        if (op == mwxss_pkg::OP_LOAD && idx < BUTTONS)
            loaded[idx] = 1'b1;
        @(negedge aclk);
    endtask

    // Hold off the sender until every solve answer has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (book.pending() != 0);
    endtask

    // One random request. Loads tend to extend the loaded prefix, and most
    // targets are built from the masks in use so that solves find matches.
    task automatic random_item(output bit counted);
        int             r;
        int             w;
        int             cap;
        mwxss_pkg::op_t op;
        bit [4:0]       idx;
        bit [15:0]      mask;
        bit [15:0]      target;
        bit [4:0]       count;
        r      = $urandom_range(0, 99);
        w      = loaded_prefix();
        idx    = 5'($urandom);
        mask   = 16'($urandom);
        target = 16'($urandom);
        count  = 5'($urandom);
        counted = 1'b1;
        if (r < 40) begin
            op = mwxss_pkg::OP_LOAD;
            if ($urandom_range(0, 9) == 0) begin
                idx = 5'($urandom_range(BUTTONS, 31));
                counted = 1'b0;
            end else if (w < BUTTONS && $urandom_range(0, 1) == 1) begin
                idx = 5'(w);
            end else begin
                idx = 5'($urandom_range(0, BUTTONS - 1));
            end
            if ($urandom_range(0, 2) == 0)
                mask = 16'h0001 << $urandom_range(0, 15);
        end else if (r < 85) begin
            op = mwxss_pkg::OP_SOLVE;
            // Long walks are rare; most solves stay at ten buttons or fewer.
            cap = ($urandom_range(0, 19) == 0) ? 16 : 10;
            if (cap > w)
                cap = w;
            count = 5'($urandom_range(0, cap));
            if ($urandom_range(0, 9) < 7) begin
                target = '0;
                for (int i = 0; i < count; i++)
                    if ($urandom_range(0, 1) == 1)
                        target ^= book.slot_mask[i];
            end
        end else if (r < 92) begin
            op = mwxss_pkg::OP_CLEAR;
        end else begin
            op = mwxss_pkg::OP_NONE;
            counted = 1'b0;
        end
        put_request(op, idx, mask, target, count);
    endtask

    // Answer side: stall at random, then take one answer and check it.
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do
                @(posedge aclk);
            while (m_valid !== 1'b1);
            book.check_result(m_min_presses, m_found, m_running_total);
            @(negedge aclk);
        end
    end

    // Main sequence: directed requests, random traffic, then one full-size solve.
    initial begin
        int done;
        bit counted;
        bit paused;
        book             = new();
        loaded           = '0;
        steady           = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_op             = mwxss_pkg::OP_LOAD;
        s_button_index   = '0;
        s_toggle_mask    = '0;
        s_target_pattern = '0;
        s_button_count   = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Unused op with every field at its top, then solves over no buttons and a clear.
        put_request(mwxss_pkg::OP_NONE, 5'd31, 16'hFFFF, 16'hFFFF, 5'd31);
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'h0000, 5'd0);
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'hFFFF, 5'd0);
        put_request(mwxss_pkg::OP_CLEAR, 5'($urandom), 16'($urandom), 16'($urandom),
                    5'($urandom));

        // Masks at the extremes; two loads outside the slot range are dropped.
        put_request(mwxss_pkg::OP_LOAD, 5'd0, 16'hFFFF, 16'($urandom), 5'($urandom));
        put_request(mwxss_pkg::OP_LOAD, 5'd1, 16'h0000, 16'($urandom), 5'($urandom));
        put_request(mwxss_pkg::OP_LOAD, 5'd2, 16'h0001, 16'($urandom), 5'($urandom));
        put_request(mwxss_pkg::OP_LOAD, 5'd3, 16'h8000, 16'($urandom), 5'($urandom));
        put_request(mwxss_pkg::OP_LOAD, 5'd4, 16'h7FFE, 16'($urandom), 5'($urandom));
        put_request(mwxss_pkg::OP_LOAD, 5'd31, 16'h1234, 16'($urandom), 5'($urandom));
        put_request(mwxss_pkg::OP_LOAD, 5'd20, 16'h00FF, 16'($urandom), 5'($urandom));

        // A single press beats three, two pairs, no match, and the zero target.
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'hFFFF, 5'd5);
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'h8001, 5'd5);
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'h7FFF, 5'd5);
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'h1234, 5'd5);
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'h0000, 5'd5);
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'hFFFF, 5'd1);

        // The total restarts after a clear and is left alone without a match.
        put_request(mwxss_pkg::OP_CLEAR, 5'($urandom), 16'($urandom), 16'($urandom),
                    5'($urandom));
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'h8001, 5'd4);
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom), 16'h0001, 5'd2);
        put_request(mwxss_pkg::OP_NONE, 5'd0, 16'h0000, 16'h0000, 5'd0);

        // Random traffic, with steady stretches and one full drain halfway.
        done   = 0;
        paused = 1'b0;
        while (done < 70) begin
            if (done % 16 == 0)
                steady = ($urandom_range(0, 3) == 0);
            random_item(counted);
            if (counted)
                done++;
            if (done >= 35 && !paused) begin
                wait_idle();
                paused = 1'b1;
            end
        end
        steady = 1'b0;

        // Fill every slot, then walk all buttons with an oversized count.
        for (int i = 0; i < BUTTONS; i++)
            if (!loaded[i])
                put_request(mwxss_pkg::OP_LOAD, 5'(i), 16'($urandom), 16'($urandom),
                            5'($urandom));
        wait_idle();
        put_request(mwxss_pkg::OP_SOLVE, 5'($urandom), 16'($urandom),
                    16'($urandom_range(1, 65535)), 5'd31);

        wait_idle();
        repeat (20) @(negedge aclk);
        book.close_out();
        if (book.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #200000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mwxss_pkg.sv
rtl/min_weight_xor_subset_search.sv
test/min_weight_xor_subset_search_test.sv
